@@ sv/fpsd_pkg.sv @@
// Shared types and constants for the fixed-point saturating divider.
`default_nettype none
package fpsd_pkg;

   localparam int DataWidth  = 32;
   localparam int FracBits   = 16;
   localparam int GuardShift = 14;
   // An unsaturated quotient magnitude stays below 2^(DataWidth-2).
   localparam int QuoWidth   = DataWidth - 2;
   localparam int NumSteps   = QuoWidth;

   localparam logic [DataWidth-1:0] SatPositive = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic [DataWidth-1:0] SatNegative = {1'b1, {(DataWidth-1){1'b0}}};

   typedef struct packed {
      logic signed [DataWidth-1:0] dividend;
      logic signed [DataWidth-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] quotient;
      logic                        saturated;
   } rsp_type;

   // State of one division as it moves down the pipeline.
   typedef struct packed {
      logic [DataWidth-1:0] rem;
      logic [QuoWidth-1:0]  low;
      logic [DataWidth-1:0] mag_divisor;
      logic [QuoWidth-1:0]  quo;
      logic                 neg;
      logic                 sat;
   } stage_type;

endpackage
`default_nettype wire

@@ sv/fpsd_div_step.sv @@
// One registered restoring-division step: retires one quotient bit per stage.
`default_nettype none
module fpsd_div_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire fpsd_pkg::stage_type in_stage,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output fpsd_pkg::stage_type     out_stage
);
   import fpsd_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   stage_type            stage_ff;
   stage_type            stage_in;
   logic [DataWidth:0]   shifted;
   logic [DataWidth+1:0] diff;
   logic                 qbit;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      // Bring down the next dividend bit and try to subtract the divisor.
      shifted = {in_stage.rem, in_stage.low[QuoWidth-1]};
      diff    = {1'b0, shifted} - {2'b00, in_stage.mag_divisor};
      qbit    = !diff[DataWidth+1];

      stage_in     = in_stage;
      stage_in.rem = qbit ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
      stage_in.low = {in_stage.low[QuoWidth-2:0], 1'b0};
      stage_in.quo = {in_stage.quo[QuoWidth-2:0], qbit};
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule
`default_nettype wire

@@ sv/fixed_point_saturating_divider_core.sv @@
`default_nettype none
// Signed Q16.16 divider with saturation: quotient = (dividend << 16) / divisor, truncated toward
// zero; when (|dividend| >> 14) >= |divisor| (always for a zero divisor) the quotient saturates to
// the most negative or most positive value by the operand signs and saturated is set. Each word
// passes an entry register for magnitudes and the guard, one pipeline stage per quotient bit for
// the 30 restoring-division steps, and an output register for the sign fix-up. A new word is
// accepted in every cycle until a stalled result has filled the pipeline; each stage holds its
// word while the one after it is full, so bubbles close up.
module fixed_point_saturating_divider_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fpsd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fpsd_pkg::rsp_type      rsp_data
);
   import fpsd_pkg::*;

   logic                 stg_valid [0:NumSteps];
   logic                 stg_ready [0:NumSteps];
   stage_type            stg_data  [0:NumSteps];

   logic                 pre_valid_ff;
   logic                 pre_valid_in;
   stage_type            pre_ff;
   stage_type            pre_in;
   logic [DataWidth-1:0] mag_a;
   logic [DataWidth-1:0] mag_b;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 out_load;
   logic [DataWidth-1:0] mag_q;

   // Entry stage: magnitudes as unsigned values, sign and overflow guard.
   assign req_ready = !pre_valid_ff || stg_ready[0];

   always_comb begin
      mag_a = req_data.dividend[DataWidth-1] ? (DataWidth'(0) - DataWidth'(req_data.dividend))
                                             : DataWidth'(req_data.dividend);
      mag_b = req_data.divisor[DataWidth-1] ? (DataWidth'(0) - DataWidth'(req_data.divisor))
                                            : DataWidth'(req_data.divisor);
      pre_in.rem         = mag_a >> GuardShift;
      pre_in.low         = {mag_a[GuardShift-1:0], {FracBits{1'b0}}};
      pre_in.mag_divisor = mag_b;
      pre_in.quo         = '0;
      pre_in.neg         = req_data.dividend[DataWidth-1] ^ req_data.divisor[DataWidth-1];
      pre_in.sat         = (mag_a >> GuardShift) >= mag_b;
   end

   always_comb begin
      pre_valid_in = pre_valid_ff;
      if (req_ready) begin
         pre_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= pre_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         pre_ff <= pre_in;
      end
   end

   assign stg_valid[0] = pre_valid_ff;
   assign stg_data[0]  = pre_ff;

   // One quotient bit per stage, most significant first.
   for (genvar k = 1; k <= NumSteps; k++) begin : g_step
      fpsd_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k-1]),
         .in_ready  (stg_ready[k-1]),
         .in_stage  (stg_data[k-1]),
         .out_valid (stg_valid[k]),
         .out_ready (stg_ready[k]),
         .out_stage (stg_data[k])
      );
   end

   // Output stage: saturation select and sign restore.
   assign out_load             = !rsp_valid_ff || rsp_ready;
   assign stg_ready[NumSteps]  = out_load;

   always_comb begin
      mag_q              = {{(DataWidth-QuoWidth){1'b0}}, stg_data[NumSteps].quo};
      rsp_in.saturated   = stg_data[NumSteps].sat;
      if (stg_data[NumSteps].sat) begin
         rsp_in.quotient = stg_data[NumSteps].neg ? SatNegative : SatPositive;
      end else if (stg_data[NumSteps].neg) begin
         rsp_in.quotient = DataWidth'(0) - mag_q;
      end else begin
         rsp_in.quotient = mag_q;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = stg_valid[NumSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && stg_valid[NumSteps]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ tb/fpsd_quotient_checker.sv @@
// Channel monitor for the divider: predicts every quotient and checks each result word in order.
module fpsd_quotient_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire fpsd_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire fpsd_pkg::rsp_type rsp_data,
   output int                     error_count,
   output int                     pending_count,
   output int                     checked_count,
   output int                     saturated_count
);
   import fpsd_pkg::*;

   rsp_type pending_quotients[$];

   function automatic rsp_type predict_quotient(req_type word);
      logic [DataWidth-1:0]   mag_dividend;
      logic [DataWidth-1:0]   mag_divisor;
      logic [DataWidth-1:0]   mag_quotient;
      logic [2*DataWidth-1:0] scaled;
      logic                   negative;
      rsp_type                expected;
      // Magnitudes are unsigned, so the most negative operand maps to 2^31 without overflow.
      mag_dividend = word.dividend[DataWidth-1] ? -word.dividend : word.dividend;
      mag_divisor  = word.divisor[DataWidth-1] ? -word.divisor : word.divisor;
      negative     = word.dividend[DataWidth-1] ^ word.divisor[DataWidth-1];
      if ((mag_dividend >> GuardShift) >= mag_divisor) begin
         expected.quotient  = negative ? SatNegative : SatPositive;
         expected.saturated = 1'b1;
      end else begin
         scaled             = {{DataWidth{1'b0}}, mag_dividend} << FracBits;
         scaled             = scaled / {{DataWidth{1'b0}}, mag_divisor};
         mag_quotient       = scaled[DataWidth-1:0];
         expected.quotient  = negative ? -mag_quotient : mag_quotient;
         expected.saturated = 1'b0;
      end
      return expected;
   endfunction

   always @(posedge clock) begin : watch_channels
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_quotients.push_back(predict_quotient(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_quotients.size() == 0) begin
               $error("result word with no division pending: quotient %h saturated %b",
                      rsp_data.quotient, rsp_data.saturated);
               error_count++;
            end else begin
               want = pending_quotients.pop_front();
               if (rsp_data.quotient !== want.quotient) begin
                  $error("quotient mismatch: expected %h, actual %h",
                         want.quotient, rsp_data.quotient);
                  error_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated mismatch: expected %b, actual %b",
                         want.saturated, rsp_data.saturated);
                  error_count++;
               end
               checked_count++;
               if (want.saturated) begin
                  saturated_count++;
               end
            end
         end
         pending_count = pending_quotients.size();
      end
   end

endmodule

@@ tb/fixed_point_saturating_divider_core_test.sv @@
// Top of the divider testbench: clock, reset, word stimulus, receiver stalls and the verdict.
module fixed_point_saturating_divider_core_test;
   import fpsd_pkg::*;

   localparam int RandomWords   = 800;
   localparam int HoldOffAfter  = 300;
   localparam int HoldOffCycles = 400;
   localparam int IdleLimit     = 5000;
   localparam int DrainCycles   = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int error_count;
   int pending_count;
   int checked_count;
   int saturated_count;
   int words_sent  = 0;
   int burst_left  = 0;
   int idle_cycles = 0;

   logic [DataWidth-1:0] extreme_values [0:5];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   fixed_point_saturating_divider_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   fpsd_quotient_checker quotient_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .saturated_count (saturated_count)
   );

   // Ends the run when neither channel has moved a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [DataWidth-1:0] with_sign(logic [DataWidth-1:0] mag, bit negative);
      return negative ? -mag : mag;
   endfunction

   // Offers one word and returns once it is accepted; valid stays high inside a burst.
   task automatic offer_word(input logic [DataWidth-1:0] dividend,
                             input logic [DataWidth-1:0] divisor);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_data.dividend = dividend;
      req_data.divisor  = divisor;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Receiver: one long hold-off once the pipeline has seen traffic, then rotating stall patterns.
   initial begin : receiver
      int  phase;
      bit  held;
      phase     = 0;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && words_sent >= HoldOffAfter) begin
            held      = 1'b1;
            rsp_ready = 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         phase++;
         case ((phase / 64) % 4)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            2: rsp_ready = (phase % 5) != 0;
            default: rsp_ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin : stimulus
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
      logic [DataWidth-1:0] mag_b;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      extreme_values[0] = 32'h7FFF_FFFF;
      extreme_values[1] = 32'h8000_0000;
      extreme_values[2] = 32'h0000_0000;
      extreme_values[3] = 32'h0000_0001;
      extreme_values[4] = 32'hFFFF_FFFF;
      extreme_values[5] = 32'h0001_0000;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Field extremes and sign combinations.
      offer_word(32'h7FFF_FFFF, 32'h0000_0001);
      offer_word(32'h8000_0000, 32'h0000_0001);
      offer_word(32'h8000_0000, 32'h8000_0000);
      offer_word(32'h8000_0000, 32'hFFFF_FFFF);
      offer_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      offer_word(32'h7FFF_FFFF, 32'h8000_0000);
      offer_word(32'h0000_0001, 32'h7FFF_FFFF);
      offer_word(32'hFFFF_FFFF, 32'h7FFF_FFFF);
      offer_word(32'h0000_0000, 32'h8000_0000);
      offer_word(32'h0000_0000, 32'hFFFF_FFFB);
      // A zero divisor saturates, signed by the dividend alone.
      offer_word(32'h0000_0000, 32'h0000_0000);
      offer_word(32'hFFFF_FFFF, 32'h0000_0000);
      offer_word(32'h0000_0005, 32'h0000_0000);
      offer_word(32'h8000_0000, 32'h0000_0000);
      // Exactly on the guard boundary, and one step below it.
      offer_word(32'h4000_0000, 32'h0001_0000);
      offer_word(32'h3FFF_FFFF, 32'h0001_0000);
      offer_word(32'hC000_0001, 32'h0001_0000);
      offer_word(32'h3FFF_FFFF, 32'hFFFF_0000);
      offer_word(32'h8000_0000, 32'h0002_0000);
      offer_word(32'h8000_0000, 32'h0002_0001);
      offer_word(32'hFFFF_C000, 32'h0000_0001);
      offer_word(32'hFFFF_C001, 32'h0000_0001);
      offer_word(32'h0001_8000, 32'hFFFE_0000);

      repeat (RandomWords) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               a = $urandom;
               b = $urandom;
            end
            3, 4: begin
               a = $urandom;
               b = with_sign($urandom >> $urandom_range(8, 31), 1'($urandom_range(0, 1)));
            end
            5, 6: begin
               // Dividend placed just around the saturation threshold of the divisor.
               mag_b = $urandom_range(1, 1 << 17);
               a = with_sign((mag_b << GuardShift) + $urandom_range(0, 4) - 2,
                             1'($urandom_range(0, 1)));
               b = with_sign(mag_b, 1'($urandom_range(0, 1)));
            end
            7: begin
               a = $urandom;
               b = '0;
            end
            8: begin
               a = extreme_values[3'($urandom_range(0, 5))];
               b = extreme_values[3'($urandom_range(0, 5))];
            end
            default: begin
               a = with_sign($urandom >> $urandom_range(0, 31), 1'($urandom_range(0, 1)));
               b = $urandom;
            end
         endcase
         offer_word(a, b);
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("Checked %0d divisions: %0d saturated, %0d exact quotients.",
               checked_count, saturated_count, checked_count - saturated_count);
      $display("Covered zero and extreme operands, the guard boundary and a %0d-cycle output stall.",
               HoldOffCycles);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/fpsd_pkg.sv
sv/fpsd_div_step.sv
sv/fixed_point_saturating_divider_core.sv
tb/fpsd_quotient_checker.sv
tb/fixed_point_saturating_divider_core_test.sv
